// ===== rtl/core/cdt_pkg.sv =====
// ----------------------------------------------------------------------------
// cdt_pkg: shared types and constants for the countdown timer
// Command codes, display view struct, result struct and the glyph decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cdt_pkg;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_START = 2'd1,
		CMD_PAUSE = 2'd2,
		CMD_STOP  = 2'd3
	} cdt_cmd_t;

	localparam int HI_W    = 5;   // whole seconds / 100, at most 1
	localparam int COUNT_MAX = 16383;
	localparam logic [7:0] DP_BIT = 8'h80;

	// state view that the segment decoder needs
	typedef struct packed {
		logic       expired;
		logic       sel;
		logic       sec_zero;
		logic       sec_ge10;
		logic [3:0] ones;
		logic [3:0] tens;
	} cdt_disp_t;

	typedef struct packed {
		logic [7:0] segments;
		logic       digit_select;
		logic       expired;
	} cdt_result_t;

	function automatic logic [7:0] glyph(input logic [3:0] d);
		logic [7:0] g;
		unique case (d)
			4'd0:    g = 8'd63;
			4'd1:    g = 8'd6;
			4'd2:    g = 8'd91;
			4'd3:    g = 8'd79;
			4'd4:    g = 8'd102;
			4'd5:    g = 8'd109;
			4'd6:    g = 8'd125;
			4'd7:    g = 8'd7;
			4'd8:    g = 8'd127;
			4'd9:    g = 8'd111;
			default: g = 8'd0;
		endcase
		return g;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/countdown_timer_seven_segment_unit.sv =====
// ----------------------------------------------------------------------------
// countdown_timer_seven_segment_unit: countdown timer with 2-digit display
// Input register, command execution in cdt_core, result register.
// ----------------------------------------------------------------------------
// Throughput: one command per cycle; the input and result registers stall
// together only when the result register is full and stalled.
// Reset: timer stopped and expired, count zero, right digit, blank segments.
`default_nettype none

module countdown_timer_seven_segment_unit #(
	parameter int TICKS_PER_SECOND = 100
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] cmd,
	input  logic [6:0] seconds,
	input  logic       pause,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] segments,
	output logic       digit_select,
	output logic       expired
);
	import cdt_pkg::*;

	logic        valid_s1;
	logic [1:0]  cmd_s1;
	logic [6:0]  seconds_s1;
	logic        pause_s1;
	logic        out_valid_q;
	cdt_result_t result_q;
	cdt_result_t result;
	logic        out_free;
	logic        advance;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			cmd_s1     <= cmd;
			seconds_s1 <= seconds;
			pause_s1   <= pause;
		end
	end

	cdt_core #(
		.TICKS_PER_SECOND(TICKS_PER_SECOND)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.cmd    (cmd_s1),
		.seconds(seconds_s1),
		.pause  (pause_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign out_valid    = out_valid_q;
	assign segments     = result_q.segments;
	assign digit_select = result_q.digit_select;
	assign expired      = result_q.expired;

endmodule

`default_nettype wire

// ===== rtl/core/cdt_seg_decode.sv =====
// ----------------------------------------------------------------------------
// cdt_seg_decode: segment byte for the selected digit
// Picks tenths, ones, tens or zero glyph, or blank, from the updated count and adds the point.
// ----------------------------------------------------------------------------
`default_nettype none

module cdt_seg_decode #(
	parameter int TICKS_PER_SECOND = 100,
	localparam int SUB_W = $clog2(TICKS_PER_SECOND)
) (
	input  cdt_pkg::cdt_disp_t disp,
	input  logic [SUB_W-1:0]   sub,
	output logic [7:0]         segments
);
	import cdt_pkg::*;

	logic [8:0] tenth_ge;
	logic [3:0] tenths;

	// tenths = floor(10*sub/TPS): thermometer of compares against ceil(k*TPS/10)
	for (genvar k = 1; k <= 9; k++) begin : g_tenth
		localparam int Thresh = (k * TICKS_PER_SECOND + 9) / 10;
		assign tenth_ge[k-1] = (sub >= SUB_W'(Thresh));
	end

	assign tenths = 4'($countones(tenth_ge));

	always_comb begin
		if (disp.expired) begin
			segments = disp.sel ? (glyph(4'd0) | DP_BIT) : glyph(4'd0);
		end else if (!disp.sel) begin
			segments = disp.sec_zero ? glyph(tenths) : glyph(disp.ones);
		end else if (disp.sec_zero) begin
			segments = glyph(4'd0) | DP_BIT;
		end else if (!disp.sec_ge10) begin
			segments = 8'd0;
		end else begin
			segments = glyph(disp.tens);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/cdt_core.sv =====
// ----------------------------------------------------------------------------
// cdt_core: timer state and command execution
// Count kept as sub-second ticks plus decimal seconds digits; one command per
// advance, result is the state after the command.
// ----------------------------------------------------------------------------
`default_nettype none

module cdt_core #(
	parameter int TICKS_PER_SECOND = 100,
	localparam int SUB_W = $clog2(TICKS_PER_SECOND)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic [1:0]           cmd,
	input  logic [6:0]           seconds,
	input  logic                 pause,
	output cdt_pkg::cdt_result_t result
);
	import cdt_pkg::*;

	// saturated load, split at elaboration
	localparam int SatSecs = COUNT_MAX / TICKS_PER_SECOND;
	localparam int SatSub  = COUNT_MAX % TICKS_PER_SECOND;
	localparam int SatHi   = SatSecs / 100;
	localparam int SatTens = (SatSecs / 10) % 10;
	localparam int SatOnes = SatSecs % 10;

	logic [SUB_W-1:0] sub_q, sub_d;
	logic [3:0]       ones_q, ones_d, tens_q, tens_d;
	logic [HI_W-1:0]  hi_q, hi_d;
	logic             running_q, running_d;
	logic             expired_q, expired_d;
	logic             sel_q, sel_d;
	logic [7:0]       seg_q, seg_d;

	logic [7:0]       load_secs;
	logic             load_hund;
	logic [6:0]       load_rem;
	logic [3:0]       load_tens;
	logic [3:0]       load_ones;
	logic             load_sat;
	logic             old_sec_zero;

	cdt_disp_t        disp;
	logic [7:0]       seg_new;

	// binary to decimal digits of seconds+1 (at most 128)
	always_comb begin
		load_secs = {1'b0, seconds} + 8'd1;
		load_hund = (load_secs >= 8'd100);
		load_rem  = load_hund ? 7'(load_secs - 8'd100) : load_secs[6:0];
		load_tens = 4'd0;
		for (int k = 1; k <= 9; k++) begin
			if (load_rem >= 7'(k * 10)) begin
				load_tens = 4'(k);
			end
		end
		load_ones = 4'(load_rem - (7'({load_tens, 3'b000}) + 7'({load_tens, 1'b0})));
		load_sat  = ({3'b000, load_secs} > 11'(SatSecs));
	end

	assign old_sec_zero = (ones_q == 4'd0) && (tens_q == 4'd0) && (hi_q == '0);

	always_comb begin
		sub_d       = sub_q;
		ones_d      = ones_q;
		tens_d      = tens_q;
		hi_d        = hi_q;
		running_d   = running_q;
		expired_d   = expired_q;
		sel_d       = sel_q;
		unique case (cdt_cmd_t'(cmd))
			CMD_TICK: begin
				if (running_q) begin
					if (sub_q != '0) begin
						sub_d = sub_q - SUB_W'(1);
					end else begin
						sub_d = SUB_W'(TICKS_PER_SECOND - 1);
						if (ones_q != 4'd0) begin
							ones_d = ones_q - 4'd1;
						end else begin
							ones_d = 4'd9;
							if (tens_q != 4'd0) begin
								tens_d = tens_q - 4'd1;
							end else begin
								tens_d = 4'd9;
								hi_d   = hi_q - HI_W'(1);
							end
						end
					end
					// last tick of the count: stop and flag timeout
					if (old_sec_zero && sub_q == SUB_W'(1)) begin
						running_d = 1'b0;
						expired_d = 1'b1;
					end
				end
				sel_d = ~sel_q;
			end
			CMD_START: begin
				if (load_sat) begin
					sub_d  = SUB_W'(SatSub);
					ones_d = 4'(SatOnes);
					tens_d = 4'(SatTens);
					hi_d   = HI_W'(SatHi);
				end else begin
					sub_d  = '0;
					ones_d = load_ones;
					tens_d = load_tens;
					hi_d   = HI_W'(load_hund);
				end
				running_d = 1'b1;
				expired_d = 1'b0;
			end
			CMD_PAUSE: begin
				if (pause) begin
					running_d = 1'b0;
				end else if (!expired_q) begin
					running_d = 1'b1;
				end
			end
			CMD_STOP: begin
				sub_d     = '0;
				ones_d    = 4'd0;
				tens_d    = 4'd0;
				hi_d      = '0;
				running_d = 1'b0;
				expired_d = 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		disp.expired  = expired_d;
		disp.sel      = sel_d;
		disp.sec_zero = (ones_d == 4'd0) && (tens_d == 4'd0) && (hi_d == '0);
		disp.sec_ge10 = (tens_d != 4'd0) || (hi_d != '0);
		disp.ones     = ones_d;
		disp.tens     = tens_d;
	end

	cdt_seg_decode #(
		.TICKS_PER_SECOND(TICKS_PER_SECOND)
	) u_seg_decode (
		.disp    (disp),
		.sub     (sub_d),
		.segments(seg_new)
	);

	assign seg_d = (cdt_cmd_t'(cmd) == CMD_TICK) ? seg_new : seg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q     <= '0;
			ones_q    <= 4'd0;
			tens_q    <= 4'd0;
			hi_q      <= '0;
			running_q <= 1'b0;
			expired_q <= 1'b1;
			sel_q     <= 1'b0;
			seg_q     <= 8'd0;
		end else if (advance) begin
			sub_q     <= sub_d;
			ones_q    <= ones_d;
			tens_q    <= tens_d;
			hi_q      <= hi_d;
			running_q <= running_d;
			expired_q <= expired_d;
			sel_q     <= sel_d;
			seg_q     <= seg_d;
		end
	end

	assign result.segments     = seg_d;
	assign result.digit_select = sel_d;
	assign result.expired      = expired_d;

endmodule

`default_nettype wire
